### hdl/bsb_pkg.sv
package bsb_pkg;

    // store size in bytes
    localparam int BUF_BYTES   = 256;
    localparam int CAP_BITS    = BUF_BYTES * 8;
    localparam int ADDR_W      = $clog2(BUF_BYTES);
    localparam int LEN_W       = $clog2(CAP_BITS + 1);
    // compare width that holds the length and an 8 bit count with room for +8
    localparam int CMP_W       = ((LEN_W > 8) ? LEN_W : 8) + 1;
    localparam int LEADING_MAX = 16;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int LENOUT_W = 12;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_LEADING  = 2'd1,
        OP_TRUNCATE = 2'd2,
        OP_TRAILING = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

endpackage

### hdl/bsb_ram.sv
module bsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

### hdl/bit_string_stack_buffer_top.sv
// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_stall   i_operation, i_data_byte, i_bit_count
// result    out        o_out_valid / i_out_stall o_leading_value, o_length_bits, o_status
//
// single ram with one write and one registered read port; one request in flight
// append writes on acceptance, then S_APP merges the partial top byte when unaligned;
// leading does three window reads (S_LD0, S_LD1, S_LD2), then the result; truncate,
// trailing, zero count leading and every failing request go straight to commit (S_FIN)
// synchronous active low reset empties the string; store contents stay as they are
// a stalled result holds in the output register; the next request waits in its final cycle
module bit_string_stack_buffer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bsb_pkg::OP_W-1:0]      i_operation,
    input  logic [bsb_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic [bsb_pkg::COUNT_W-1:0]   i_bit_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bsb_pkg::VALUE_W-1:0]   o_leading_value,
    output logic [bsb_pkg::LENOUT_W-1:0]  o_length_bits,
    output logic [bsb_pkg::STATUS_W-1:0]  o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP,
        S_LD0,
        S_LD1,
        S_LD2,
        S_FIN
    } t_state;

    t_state r_state;

    // string length in bits
    logic [bsb_pkg::LEN_W-1:0]    r_len;

    // per request working registers
    logic [bsb_pkg::ADDR_W-1:0]   r_idx;
    logic [2:0]                   r_rem;
    logic [bsb_pkg::BYTE_W-1:0]   r_data;
    logic [bsb_pkg::ADDR_W-1:0]   r_rd_idx;
    logic [2:0]                   r_sh;
    logic [4:0]                   r_cnt;
    logic [bsb_pkg::BYTE_W-1:0]   r_b0;
    logic [bsb_pkg::BYTE_W-1:0]   r_b1;

    // pending result
    logic [bsb_pkg::VALUE_W-1:0]  r_res_value;
    logic [bsb_pkg::LEN_W-1:0]    r_res_len;
    bsb_pkg::t_status             r_res_status;

    // output register
    logic                         r_out_valid;
    logic [bsb_pkg::VALUE_W-1:0]  r_out_value;
    logic [bsb_pkg::LEN_W-1:0]    r_out_len;
    bsb_pkg::t_status             r_out_status;

    logic                         accept;
    logic                         out_free;
    bsb_pkg::t_op                 op;
    logic [bsb_pkg::CMP_W-1:0]    len_c;
    logic [bsb_pkg::CMP_W-1:0]    cnt_c;
    logic [bsb_pkg::CMP_W-1:0]    start_c;
    logic                         app_ovf;
    logic                         cnt_err;
    logic                         ld_err;
    logic [2:0]                   len_rem;
    logic [bsb_pkg::ADDR_W-1:0]   len_idx;
    logic [bsb_pkg::ADDR_W-1:0]   start_idx;

    logic                         ram_wr_en;
    logic [bsb_pkg::ADDR_W-1:0]   ram_wr_addr;
    logic [bsb_pkg::BYTE_W-1:0]   ram_wr_data;
    logic [bsb_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [bsb_pkg::BYTE_W-1:0]   ram_rd_data;

    logic [3*bsb_pkg::BYTE_W-1:0] win;
    logic [3*bsb_pkg::BYTE_W-1:0] win_sh;
    logic [bsb_pkg::VALUE_W-1:0]  ld_mask;
    logic [bsb_pkg::VALUE_W-1:0]  ld_value;
    logic [bsb_pkg::BYTE_W-1:0]   keep_mask;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign op       = bsb_pkg::t_op'(i_operation);

    // request decode against the current length
    assign len_c     = bsb_pkg::CMP_W'(r_len);
    assign cnt_c     = bsb_pkg::CMP_W'(i_bit_count);
    assign start_c   = len_c - cnt_c;
    assign app_ovf   = (len_c + bsb_pkg::CMP_W'(8)) > bsb_pkg::CMP_W'(bsb_pkg::CAP_BITS);
    assign cnt_err   = cnt_c > len_c;
    assign ld_err    = cnt_err || (cnt_c > bsb_pkg::CMP_W'(bsb_pkg::LEADING_MAX));
    assign len_rem   = r_len[2:0];
    assign len_idx   = bsb_pkg::ADDR_W'(r_len >> 3);
    assign start_idx = bsb_pkg::ADDR_W'(start_c >> 3);

    // low bits of the partial top byte that survive an unaligned append
    assign keep_mask = bsb_pkg::BYTE_W'((9'd1 << r_rem) - 9'd1);

    // ram port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = len_idx;
        ram_wr_data = i_data_byte;
        if (accept && (op == bsb_pkg::OP_APPEND) && !app_ovf) begin
            ram_wr_en = 1'b1;
            if (len_rem != 3'd0) begin
                // upper part of the byte lands in the next entry
                ram_wr_addr = len_idx + 1'b1;
                ram_wr_data = i_data_byte >> (4'd8 - {1'b0, len_rem});
            end
        end else if (r_state == S_APP) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_idx;
            ram_wr_data = (ram_rd_data & keep_mask) | (r_data << r_rem);
        end
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            ram_rd_addr = (op == bsb_pkg::OP_LEADING) ? start_idx : len_idx;
        end else begin
            ram_rd_addr = r_rd_idx + 1'b1;
        end
    end

    bsb_ram #(
        .WIDTH (bsb_pkg::BYTE_W),
        .DEPTH (bsb_pkg::BUF_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // leading window: three bytes, shifted down to the start bit and masked to the count
    assign win      = {ram_rd_data, r_b1, r_b0};
    assign win_sh   = win >> r_sh;
    assign ld_mask  = bsb_pkg::VALUE_W'((17'd1 << r_cnt) - 17'd1);
    assign ld_value = win_sh[bsb_pkg::VALUE_W-1:0] & ld_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_idx <= ram_rd_addr;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx        <= len_idx;
                        r_rem        <= len_rem;
                        r_data       <= i_data_byte;
                        r_sh         <= start_c[2:0];
                        r_cnt        <= i_bit_count[4:0];
                        r_res_value  <= '0;
                        r_res_len    <= r_len;
                        r_res_status <= bsb_pkg::ST_OK;
                        r_state      <= S_FIN;
                        unique case (op)
                            bsb_pkg::OP_APPEND: begin
                                if (app_ovf) begin
                                    r_res_status <= bsb_pkg::ST_OVERFLOW;
                                end else begin
                                    r_res_len <= bsb_pkg::LEN_W'(len_c + bsb_pkg::CMP_W'(8));
                                    if (len_rem != 3'd0) begin
                                        r_state <= S_APP;
                                    end
                                end
                            end
                            bsb_pkg::OP_LEADING: begin
                                if (ld_err) begin
                                    r_res_status <= bsb_pkg::ST_RANGE;
                                end else if (i_bit_count != '0) begin
                                    r_state <= S_LD0;
                                end
                            end
                            bsb_pkg::OP_TRUNCATE: begin
                                if (cnt_err) begin
                                    r_res_status <= bsb_pkg::ST_RANGE;
                                end else begin
                                    r_res_len <= bsb_pkg::LEN_W'(start_c);
                                end
                            end
                            bsb_pkg::OP_TRAILING: begin
                                if (cnt_err) begin
                                    r_res_status <= bsb_pkg::ST_RANGE;
                                end else begin
                                    r_res_len <= bsb_pkg::LEN_W'(cnt_c);
                                end
                            end
                            default: begin
                                r_res_status <= bsb_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_APP: begin
                    r_state <= S_FIN;
                end
                S_LD0: begin
                    r_b0    <= ram_rd_data;
                    r_state <= S_LD1;
                end
                S_LD1: begin
                    r_b1    <= ram_rd_data;
                    r_state <= S_LD2;
                end
                S_LD2: begin
                    r_res_value <= ld_value;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    // commit once the output register can take the result
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_len    <= r_res_len;
                        r_out_status <= r_res_status;
                        r_len        <= r_res_len;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_leading_value = r_out_value;
    assign o_length_bits   = bsb_pkg::LENOUT_W'(r_out_len);
    assign o_status        = r_out_status;

`ifndef SYNTH
    // the string never grows past the store capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= bsb_pkg::LEN_W'(bsb_pkg::CAP_BITS))
        else $error("length beyond capacity");

    // leading reads and the commit cycle never write the store
    a_no_wr_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD0 || r_state == S_LD1 || r_state == S_LD2 || r_state == S_FIN)
        |-> !ram_wr_en)
        else $error("store written outside append");

    // a new result only appears out of the commit cycle
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without commit");
`endif

endmodule

### tb/testbench.sv
module testbench;

    // one result as the block should report it
    typedef struct {
        logic [bsb_pkg::VALUE_W-1:0]  value;
        logic [bsb_pkg::LENOUT_W-1:0] len_bits;
        bsb_pkg::t_status             status;
    } t_result;

    // shadow copy of the bit string; works out each result as requests go in
    class t_bit_string_shadow;
        logic [7:0] bytes [bsb_pkg::BUF_BYTES];
        int         length;
        t_result    results_due [$];
        int         errors;

        function new();
            foreach (bytes[k]) bytes[k] = 8'h00;
            length = 0;
            errors = 0;
        endfunction

        // clear the unused bits of the new last byte
        function void clear_above_top();
            int idx;
            int r;
            idx = length >> 3;
            r = length & 7;
            if (r != 0 && idx < bsb_pkg::BUF_BYTES)
                bytes[idx] = bytes[idx] & 8'((1 << r) - 1);
        endfunction

        function void note_request(bsb_pkg::t_op op, logic [7:0] data, logic [7:0] count);
            t_result     res;
            int          idx;
            int          r;
            int          pos;
            int          n;
            logic [15:0] shifted;
            n = int'(count);
            res.value = '0;
            res.status = bsb_pkg::ST_OK;
            case (op)
                bsb_pkg::OP_APPEND: begin
                    if (length + 8 > bsb_pkg::CAP_BITS) begin
                        res.status = bsb_pkg::ST_OVERFLOW;
                    end else begin
                        idx = length >> 3;
                        r = length & 7;
                        shifted = 16'(data) << r;
                        if (r == 0) begin
                            bytes[idx] = data;
                        end else begin
                            bytes[idx] = (bytes[idx] & 8'((1 << r) - 1)) | shifted[7:0];
                            if (idx + 1 < bsb_pkg::BUF_BYTES)
                                bytes[idx + 1] = shifted[15:8];
                        end
                        length += 8;
                    end
                end
                bsb_pkg::OP_LEADING: begin
                    if (n > bsb_pkg::LEADING_MAX || n > length) begin
                        res.status = bsb_pkg::ST_RANGE;
                    end else begin
                        for (int k = 0; k < n; k++) begin
                            pos = length - n + k;
                            res.value[k] = bytes[pos >> 3][pos & 7];
                        end
                    end
                end
                bsb_pkg::OP_TRUNCATE: begin
                    if (n > length) begin
                        res.status = bsb_pkg::ST_RANGE;
                    end else begin
                        length -= n;
                        clear_above_top();
                    end
                end
                default: begin
                    if (n > length) begin
                        res.status = bsb_pkg::ST_RANGE;
                    end else begin
                        length = n;
                        clear_above_top();
                    end
                end
            endcase
            res.len_bits = bsb_pkg::LENOUT_W'(length);
            results_due.push_back(res);
        endfunction

        function void check_result(logic [bsb_pkg::VALUE_W-1:0] value,
                                   logic [bsb_pkg::LENOUT_W-1:0] len_bits,
                                   logic [bsb_pkg::STATUS_W-1:0] status);
            t_result exp_res;
            if (results_due.size() == 0) begin
                $error("result with nothing outstanding: value %0h length %0d status %0d",
                       value, len_bits, status);
                errors++;
                return;
            end
            exp_res = results_due.pop_front();
            if (value !== exp_res.value) begin
                $error("leading_value: expected %0h, got %0h", exp_res.value, value);
                errors++;
            end
            if (len_bits !== exp_res.len_bits) begin
                $error("length_bits: expected %0d, got %0d", exp_res.len_bits, len_bits);
                errors++;
            end
            if (status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    // clock, reset and block ports
    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [bsb_pkg::OP_W-1:0]      i_operation = bsb_pkg::OP_APPEND;
    logic [bsb_pkg::BYTE_W-1:0]    i_data_byte = '0;
    logic [bsb_pkg::COUNT_W-1:0]   i_bit_count = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [bsb_pkg::VALUE_W-1:0]   o_leading_value;
    logic [bsb_pkg::LENOUT_W-1:0]  o_length_bits;
    logic [bsb_pkg::STATUS_W-1:0]  o_status;

    t_bit_string_shadow shadow = new();

    // sender burst bookkeeping
    int burst_left = 0;

    // results taken so far, drives the long receiver hold-off
    int results_seen = 0;

    bit_string_stack_buffer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_bit_count     (i_bit_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_leading_value (o_leading_value),
        .o_length_bits   (o_length_bits),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // sender pacing: bursts of random length, random idle gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_request(bsb_pkg::t_op op, logic [7:0] data, logic [7:0] count);
        pace_sender();
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        i_bit_count <= count;
        do @(posedge i_clk); while (o_in_stall);
        shadow.note_request(op, data, count);
    endtask

    // mostly well-formed requests sized to the current length, some raw noise
    task automatic send_mixed(int num);
        int           pick;
        int           len;
        int           hi;
        int           lo;
        int           n;
        bsb_pkg::t_op op;
        repeat (num) begin
            pick = $urandom_range(0, 99);
            len = shadow.length;
            if (pick < 40)      op = bsb_pkg::OP_APPEND;
            else if (pick < 65) op = bsb_pkg::OP_LEADING;
            else if (pick < 85) op = bsb_pkg::OP_TRUNCATE;
            else                op = bsb_pkg::OP_TRAILING;
            n = $urandom_range(0, 255);
            if ($urandom_range(0, 9) != 0) begin
                case (op)
                    bsb_pkg::OP_LEADING: begin
                        n = $urandom_range(0, (len < bsb_pkg::LEADING_MAX) ?
                                              len : bsb_pkg::LEADING_MAX);
                    end
                    bsb_pkg::OP_TRUNCATE: n = $urandom_range(0, (len < 20) ? len : 20);
                    bsb_pkg::OP_TRAILING: begin
                        hi = (len < 255) ? len : 255;
                        lo = (hi > 24) ? hi - 24 : 0;
                        n = $urandom_range(lo, hi);
                    end
                    default: ;
                endcase
            end
            send_request(op, 8'($urandom), 8'(n));
        end
    endtask

    // run the string up to the top of the store and push past it
    task automatic fill_store();
        while (shadow.length + 8 <= bsb_pkg::CAP_BITS)
            send_request(bsb_pkg::OP_APPEND, 8'($urandom), 8'($urandom));
        repeat (2) send_request(bsb_pkg::OP_APPEND, 8'($urandom), 8'($urandom));
        // square the length to a byte boundary so the string reaches exactly full
        if ((shadow.length & 7) != 0)
            send_request(bsb_pkg::OP_TRUNCATE, 8'($urandom), 8'(shadow.length & 7));
        while (shadow.length + 8 <= bsb_pkg::CAP_BITS)
            send_request(bsb_pkg::OP_APPEND, 8'($urandom), 8'($urandom));
        send_request(bsb_pkg::OP_APPEND, 8'hff, 8'h00);
        send_request(bsb_pkg::OP_LEADING, 8'($urandom), 8'd16);
        send_request(bsb_pkg::OP_TRUNCATE, 8'($urandom), 8'd255);
        send_request(bsb_pkg::OP_TRUNCATE, 8'($urandom), 8'd7);
        send_request(bsb_pkg::OP_APPEND, 8'h96, 8'($urandom));
        send_request(bsb_pkg::OP_LEADING, 8'($urandom), 8'd11);
        send_request(bsb_pkg::OP_TRAILING, 8'($urandom), 8'd100);
    endtask

    // receiver: take results, stall in stretches of its own, one long hold-off
    initial begin
        int  hold_left;
        int  mode;
        int  mode_left;
        bit  hold_done;
        bit  stall;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                shadow.check_result(o_leading_value, o_length_bits, o_status);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else if (!hold_done && results_seen >= 60) begin
                // long hold-off so the block backs up and stalls its input
                hold_done = 1'b1;
                hold_left = 150;
                stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       stall = 1'b0;
                    1:       stall = ($urandom_range(0, 3) == 0);
                    default: stall = ($urandom_range(0, 3) != 0);
                endcase
            end
            i_out_stall <= stall;
        end
    end

    // main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty string corner cases
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd0);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd1);
        send_request(bsb_pkg::OP_TRUNCATE, 8'h00, 8'd0);
        send_request(bsb_pkg::OP_TRUNCATE, 8'h00, 8'd1);
        send_request(bsb_pkg::OP_TRAILING, 8'h00, 8'd0);
        send_request(bsb_pkg::OP_TRAILING, 8'hff, 8'd255);
        // byte-aligned appends, then a cut that leaves a partial top byte
        send_request(bsb_pkg::OP_APPEND, 8'hff, 8'd0);
        send_request(bsb_pkg::OP_APPEND, 8'h00, 8'd255);
        send_request(bsb_pkg::OP_TRUNCATE, 8'h00, 8'd3);
        // unaligned append, must land cleanly above the cut
        send_request(bsb_pkg::OP_APPEND, 8'ha5, 8'h00);
        // leading window over three bytes, past its limit, past the length
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd16);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd17);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd255);
        // leading window wholly inside the top byte
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd5);
        send_request(bsb_pkg::OP_TRAILING, 8'h00, 8'd5);
        send_request(bsb_pkg::OP_APPEND, 8'h3c, 8'h00);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd13);
        // truncate the whole string, then rebuild
        send_request(bsb_pkg::OP_TRUNCATE, 8'h00, 8'd13);
        send_request(bsb_pkg::OP_APPEND, 8'h81, 8'h00);
        send_request(bsb_pkg::OP_TRAILING, 8'h00, 8'd8);
        send_request(bsb_pkg::OP_TRUNCATE, 8'h00, 8'd255);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd8);
        send_request(bsb_pkg::OP_APPEND, 8'h5a, 8'd255);
        send_request(bsb_pkg::OP_LEADING, 8'h00, 8'd1);

        // random traffic, a full-store excursion, more random traffic
        send_mixed(80);
        fill_store();
        send_mixed(70);

        i_in_valid <= 1'b0;
        while (shadow.pending() > 0) @(posedge i_clk);
        // let any stray result show up
        repeat (20) @(posedge i_clk);

        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
